@@ src/recency_slot_list_with_expiry_macros.svh @@
// Assertion macros shared by the recency slot list RTL.
`ifndef RECENCY_SLOT_LIST_WITH_EXPIRY_MACROS_SVH
`define RECENCY_SLOT_LIST_WITH_EXPIRY_MACROS_SVH
`ifndef SYNTHESIS
// Implication in the same cycle.
`define RSL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("recency slot list: property violated");
// Implication into the following cycle.
`define RSL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("recency slot list: property violated");
`else
`define RSL_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RSL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ src/rsl_pkg.sv @@
// Types and fixed constants of the recency slot list.
package rsl_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned IN_TAG_W   = 16;
    localparam int unsigned OUT_SLOT_W = 4;
    localparam int unsigned OUT_TAG_W  = 16;

    localparam logic [TIME_W-1:0] TTL_RESET = 32'd8000;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_SCAN    = 10'b00_0000_0010,
        ST_UL_RD   = 10'b00_0000_0100,
        ST_UL_WR   = 10'b00_0000_1000,
        ST_LINK_A  = 10'b00_0001_0000,
        ST_LINK_B  = 10'b00_0010_0000,
        ST_ADD_OUT = 10'b00_0100_0000,
        ST_RD      = 10'b00_1000_0000,
        ST_EVAL    = 10'b01_0000_0000,
        ST_FIN     = 10'b10_0000_0000
    } state_t;

endpackage

@@ src/rsl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rsl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/recency_slot_list_with_expiry.sv @@
// Sequence: an add scans for the lowest free slot, unlinks the oldest entry on eviction (RAM
// read, then write), links the new entry (LINK_A, then LINK_B if the ring was not empty) and
// waits for room in the result register. A tick reads, then evaluates, each entry, finishes
// and waits while the result register is stalled; one transaction is in work at a time.
// Reset (aresetn low, synchronous) empties the ring and sets time_to_live to 8000;
// no memory clearing pass is needed, so the block is ready the cycle after reset.
`include "recency_slot_list_with_expiry_macros.svh"

module recency_slot_list_with_expiry #(
    parameter int unsigned RING_SLOTS = 10,
    parameter int unsigned TAG_BITS   = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write channel: time_to_live.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsl_pkg::TIME_W-1:0]      cfg_time_to_live,
    // Input channel.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [rsl_pkg::IN_TAG_W-1:0]    s_entry_tag,
    input  logic [rsl_pkg::TIME_W-1:0]      s_now_time,
    // Result channel.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rsl_pkg::OUT_SLOT_W-1:0]  m_slot_index,
    output logic [rsl_pkg::OUT_TAG_W-1:0]   m_slot_tag,
    output logic                            m_evicted,
    output logic                            m_present,
    output logic                            m_last_result
);

    // Slot 0 is the sentinel. Its two links live in head_reg (newest entry)
    // and tail_reg (oldest entry), so the link RAMs are only ever read at
    // live slots, each of which was written when it was linked in.
    localparam int unsigned SLOT_W = $clog2(RING_SLOTS);
    localparam int unsigned TW     = rsl_pkg::TIME_W;

    rsl_pkg::state_t state_reg, state_next;

    logic [TW-1:0]         ttl_reg, ttl_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [SLOT_W-1:0]     tail_reg, tail_next;
    logic [RING_SLOTS-1:0] used_reg, used_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [SLOT_W-1:0]     steps_reg, steps_next;
    logic [SLOT_W-1:0]     link_old_reg, link_old_next;
    logic                  evict_reg, evict_next;

    // Operands of the transaction in work.
    logic [TAG_BITS-1:0]   tag_reg, tag_next;
    logic [TW-1:0]         now_reg, now_next;

    // The latest survivor of a tick is held back until we know whether it
    // is the last one, since last_result must mark the final result.
    logic                  pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]     pend_slot_reg, pend_slot_next;
    logic [TAG_BITS-1:0]   pend_tag_reg, pend_tag_next;

    // Output register.
    logic                                m_valid_reg, m_valid_next;
    logic [rsl_pkg::OUT_SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [rsl_pkg::OUT_TAG_W-1:0]       out_tag_reg, out_tag_next;
    logic                                out_evicted_reg, out_evicted_next;
    logic                                out_present_reg, out_present_next;
    logic                                out_last_reg, out_last_next;

    // Link, stamp and tag RAMs, all read at cur_reg.
    logic                  next_we, prev_we, stamp_we, tagm_we;
    logic [SLOT_W-1:0]     next_waddr, prev_waddr, stamp_waddr, tagm_waddr;
    logic [SLOT_W-1:0]     next_wdata, prev_wdata;
    logic [TW-1:0]         stamp_wdata;
    logic [TAG_BITS-1:0]   tagm_wdata;
    logic [SLOT_W-1:0]     next_q, prev_q;
    logic [TW-1:0]         stamp_q;
    logic [TAG_BITS-1:0]   tag_q;

    logic                  out_free;
    logic                  unlink_en;
    logic [TW-1:0]         stamp_eff;
    logic [TW-1:0]         age;
    logic                  expire;

    // Width adaptation between the parameterized store and the fixed ports.
    logic [TAG_BITS+rsl_pkg::IN_TAG_W-1:0]   in_tag_ext;
    logic [TAG_BITS+rsl_pkg::OUT_TAG_W-1:0]  add_tag_ext, pend_tag_ext;
    logic [SLOT_W+rsl_pkg::OUT_SLOT_W-1:0]   cur_slot_ext, pend_slot_ext;

    assign in_tag_ext    = {{TAG_BITS{1'b0}}, s_entry_tag};
    assign add_tag_ext   = {{rsl_pkg::OUT_TAG_W{1'b0}}, tag_reg};
    assign pend_tag_ext  = {{rsl_pkg::OUT_TAG_W{1'b0}}, pend_tag_reg};
    assign cur_slot_ext  = {{rsl_pkg::OUT_SLOT_W{1'b0}}, cur_reg};
    assign pend_slot_ext = {{rsl_pkg::OUT_SLOT_W{1'b0}}, pend_slot_reg};

    rsl_ram #(.WIDTH(SLOT_W), .DEPTH(RING_SLOTS)) u_next_ram (
        .aclk (aclk), .we (next_we), .waddr (next_waddr), .wdata (next_wdata),
        .raddr (cur_reg), .rdata (next_q)
    );

    rsl_ram #(.WIDTH(SLOT_W), .DEPTH(RING_SLOTS)) u_prev_ram (
        .aclk (aclk), .we (prev_we), .waddr (prev_waddr), .wdata (prev_wdata),
        .raddr (cur_reg), .rdata (prev_q)
    );

    rsl_ram #(.WIDTH(TW), .DEPTH(RING_SLOTS)) u_stamp_ram (
        .aclk (aclk), .we (stamp_we), .waddr (stamp_waddr), .wdata (stamp_wdata),
        .raddr (cur_reg), .rdata (stamp_q)
    );

    rsl_ram #(.WIDTH(TAG_BITS), .DEPTH(RING_SLOTS)) u_tag_ram (
        .aclk (aclk), .we (tagm_we), .waddr (tagm_waddr), .wdata (tagm_wdata),
        .raddr (cur_reg), .rdata (tag_q)
    );

    // The shared age unit: one 32-bit wrapping subtract and one compare.
    // A zero stamp means "not yet seen by a tick" and takes the current time.
    assign stamp_eff = (stamp_q == '0) ? now_reg : stamp_q;
    assign age       = now_reg - stamp_eff;
    assign expire    = (age > ttl_reg);

    // The output register can take a new result when empty or being drained.
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready   = (state_reg == rsl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_valid       = m_valid_reg;
    assign m_slot_index  = out_slot_reg;
    assign m_slot_tag    = out_tag_reg;
    assign m_evicted     = out_evicted_reg;
    assign m_present     = out_present_reg;
    assign m_last_result = out_last_reg;

    always_comb begin
        state_next      = state_reg;
        ttl_next        = ttl_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        used_next       = used_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        link_old_next   = link_old_reg;
        evict_next      = evict_reg;
        tag_next        = tag_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;

        m_valid_next     = m_valid_reg && !m_ready;
        out_slot_next    = out_slot_reg;
        out_tag_next     = out_tag_reg;
        out_evicted_next = out_evicted_reg;
        out_present_next = out_present_reg;
        out_last_next    = out_last_reg;

        next_we     = 1'b0;
        next_waddr  = '0;
        next_wdata  = '0;
        prev_we     = 1'b0;
        prev_waddr  = '0;
        prev_wdata  = '0;
        stamp_we    = 1'b0;
        stamp_waddr = '0;
        stamp_wdata = '0;
        tagm_we     = 1'b0;
        tagm_waddr  = '0;
        tagm_wdata  = '0;
        unlink_en   = 1'b0;

        if (cfg_valid) begin
            ttl_next = cfg_time_to_live;
        end

        unique case (state_reg)
            rsl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    tag_next = in_tag_ext[TAG_BITS-1:0];
                    now_next = s_now_time;
                    if (s_kind == rsl_pkg::KIND_ADD) begin
                        // Scan for the lowest free slot, starting after the sentinel.
                        cur_next   = SLOT_W'(1);
                        state_next = rsl_pkg::ST_SCAN;
                    end else begin
                        cur_next   = head_reg;
                        steps_next = '0;
                        state_next = (head_reg == '0) ? rsl_pkg::ST_FIN : rsl_pkg::ST_RD;
                    end
                end
            end

            rsl_pkg::ST_SCAN: begin
                if (!used_reg[cur_reg]) begin
                    evict_next = 1'b0;
                    state_next = rsl_pkg::ST_LINK_A;
                end else if (cur_reg == SLOT_W'(RING_SLOTS - 1)) begin
                    // Table full: the oldest entry gives up its slot.
                    evict_next = 1'b1;
                    if (tail_reg == '0) begin
                        cur_next   = SLOT_W'(1);
                        state_next = rsl_pkg::ST_LINK_A;
                    end else begin
                        cur_next   = tail_reg;
                        state_next = rsl_pkg::ST_UL_RD;
                    end
                end else begin
                    cur_next = cur_reg + SLOT_W'(1);
                end
            end

            rsl_pkg::ST_UL_RD: begin
                state_next = rsl_pkg::ST_UL_WR;
            end

            rsl_pkg::ST_UL_WR: begin
                unlink_en  = 1'b1;
                state_next = rsl_pkg::ST_LINK_A;
            end

            rsl_pkg::ST_LINK_A: begin
                // Link cur_reg in as newest and initialize its entry.
                next_we     = 1'b1;
                next_waddr  = cur_reg;
                next_wdata  = head_reg;
                prev_we     = 1'b1;
                prev_waddr  = cur_reg;
                prev_wdata  = '0;
                stamp_we    = 1'b1;
                stamp_waddr = cur_reg;
                stamp_wdata = '0;
                tagm_we     = 1'b1;
                tagm_waddr  = cur_reg;
                tagm_wdata  = tag_reg;
                used_next[cur_reg] = 1'b1;
                head_next   = cur_reg;
                if (head_reg == '0) begin
                    tail_next  = cur_reg;
                    state_next = rsl_pkg::ST_ADD_OUT;
                end else begin
                    link_old_next = head_reg;
                    state_next    = rsl_pkg::ST_LINK_B;
                end
            end

            rsl_pkg::ST_LINK_B: begin
                // The former newest entry now points back at the new one.
                prev_we    = 1'b1;
                prev_waddr = link_old_reg;
                prev_wdata = cur_reg;
                state_next = rsl_pkg::ST_ADD_OUT;
            end

            rsl_pkg::ST_ADD_OUT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    out_slot_next    = cur_slot_ext[rsl_pkg::OUT_SLOT_W-1:0];
                    out_tag_next     = add_tag_ext[rsl_pkg::OUT_TAG_W-1:0];
                    out_evicted_next = evict_reg;
                    out_present_next = 1'b1;
                    out_last_next    = 1'b1;
                    state_next       = rsl_pkg::ST_IDLE;
                end
            end

            rsl_pkg::ST_RD: begin
                state_next = rsl_pkg::ST_EVAL;
            end

            rsl_pkg::ST_EVAL: begin
                // A survivor with a held one pushes that one out, so it waits for room
                // in the output register; an expiry never waits.
                if (expire || !pend_valid_reg || out_free) begin
                    if (stamp_q == '0) begin
                        stamp_we    = 1'b1;
                        stamp_waddr = cur_reg;
                        stamp_wdata = now_reg;
                    end
                    if (expire) begin
                        unlink_en = 1'b1;
                    end else begin
                        if (pend_valid_reg) begin
                            m_valid_next     = 1'b1;
                            out_slot_next    = pend_slot_ext[rsl_pkg::OUT_SLOT_W-1:0];
                            out_tag_next     = pend_tag_ext[rsl_pkg::OUT_TAG_W-1:0];
                            out_evicted_next = 1'b0;
                            out_present_next = 1'b1;
                            out_last_next    = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = cur_reg;
                        pend_tag_next   = tag_q;
                    end
                    cur_next   = next_q;
                    steps_next = steps_reg + SLOT_W'(1);
                    if (next_q == '0 || steps_reg == SLOT_W'(RING_SLOTS - 2)) begin
                        state_next = rsl_pkg::ST_FIN;
                    end else begin
                        state_next = rsl_pkg::ST_RD;
                    end
                end
            end

            rsl_pkg::ST_FIN: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    out_evicted_next = 1'b0;
                    out_last_next    = 1'b1;
                    if (pend_valid_reg) begin
                        out_slot_next    = pend_slot_ext[rsl_pkg::OUT_SLOT_W-1:0];
                        out_tag_next     = pend_tag_ext[rsl_pkg::OUT_TAG_W-1:0];
                        out_present_next = 1'b1;
                    end else begin
                        out_slot_next    = '0;
                        out_tag_next     = '0;
                        out_present_next = 1'b0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = rsl_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = rsl_pkg::ST_IDLE;
            end
        endcase

        // Unlink cur_reg: its neighbors, just read from the link RAMs, are
        // joined, with the sentinel's links held in head_reg and tail_reg.
        if (unlink_en) begin
            if (prev_q == '0) begin
                head_next = next_q;
            end else begin
                next_we    = 1'b1;
                next_waddr = prev_q;
                next_wdata = next_q;
            end
            if (next_q == '0) begin
                tail_next = prev_q;
            end else begin
                prev_we    = 1'b1;
                prev_waddr = next_q;
                prev_wdata = prev_q;
            end
            used_next[cur_reg] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rsl_pkg::ST_IDLE;
            ttl_reg        <= rsl_pkg::TTL_RESET;
            head_reg       <= '0;
            tail_reg       <= '0;
            used_reg       <= {{(RING_SLOTS-1){1'b0}}, 1'b1};
            cur_reg        <= '0;
            steps_reg      <= '0;
            evict_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ttl_reg        <= ttl_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            used_reg       <= used_next;
            cur_reg        <= cur_next;
            steps_reg      <= steps_next;
            evict_reg      <= evict_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        link_old_reg    <= link_old_next;
        tag_reg         <= tag_next;
        now_reg         <= now_next;
        pend_slot_reg   <= pend_slot_next;
        pend_tag_reg    <= pend_tag_next;
        out_slot_reg    <= out_slot_next;
        out_tag_reg     <= out_tag_next;
        out_evicted_reg <= out_evicted_next;
        out_present_reg <= out_present_next;
        out_last_reg    <= out_last_next;
    end

    // Between transactions the ring is either empty at both ends or at neither.
    `RSL_ASSERT_IMP(a_ring_ends_agree, aclk, aresetn, state_reg == rsl_pkg::ST_IDLE, (head_reg == '0) == (tail_reg == '0))
    // Between transactions, the newest entry is a claimed slot.
    `RSL_ASSERT_IMP(a_head_is_used, aclk, aresetn, state_reg == rsl_pkg::ST_IDLE && head_reg != '0, used_reg[head_reg])
    // A held survivor exists only while a tick walks the ring.
    `RSL_ASSERT_IMP(a_pend_in_walk, aclk, aresetn, pend_valid_reg, state_reg == rsl_pkg::ST_RD || state_reg == rsl_pkg::ST_EVAL || state_reg == rsl_pkg::ST_FIN)
    // One transaction at a time: acceptance closes the input side.
    `RSL_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

@@ dv/recency_slot_list_with_expiry_tb.sv @@
// Self-checking testbench for the recency slot list with expiry, predicting every result.
`timescale 1ns / 1ps

module recency_slot_list_with_expiry_tb;

    localparam int unsigned RING_SLOTS = 10;
    localparam int unsigned TAG_BITS   = 16;
    // Cycles without any accepted transaction before the run is declared hung.
    localparam int unsigned STALL_LIMIT = 5000;
    // Extra cycles after the last expected result, to catch stray results.
    localparam int unsigned TAIL_CYCLES = 40;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic [rsl_pkg::OUT_SLOT_W-1:0] slot_index;
        logic [rsl_pkg::OUT_TAG_W-1:0]  slot_tag;
        logic                           evicted;
        logic                           present;
        logic                           last_result;
    } slot_report_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                           cfg_valid        = 1'b0;
    logic                           cfg_ready;
    logic [rsl_pkg::TIME_W-1:0]     cfg_time_to_live = '0;

    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    logic                           s_kind      = rsl_pkg::KIND_ADD;
    logic [rsl_pkg::IN_TAG_W-1:0]   s_entry_tag = '0;
    logic [rsl_pkg::TIME_W-1:0]     s_now_time  = '0;

    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [rsl_pkg::OUT_SLOT_W-1:0] m_slot_index;
    logic [rsl_pkg::OUT_TAG_W-1:0]  m_slot_tag;
    logic                           m_evicted;
    logic                           m_present;
    logic                           m_last_result;

    // Shadow copy of the ring, the slot table and the expiry register.
    logic [3:0]                 prev_link [RING_SLOTS];
    logic [3:0]                 next_link [RING_SLOTS];
    bit                         slot_busy [RING_SLOTS];
    logic [rsl_pkg::TIME_W-1:0] slot_time [RING_SLOTS];
    logic [15:0]                slot_label[RING_SLOTS];
    logic [rsl_pkg::TIME_W-1:0] ttl_shadow;

    // Results the block still owes, oldest first.
    slot_report_t pending_reports[$];

    int unsigned fail_count  = 0;
    int unsigned idle_cycles = 0;
    bit          no_gaps     = 1'b0;
    // Running time base for the random ticks, in milliseconds.
    logic [rsl_pkg::TIME_W-1:0] clock_ms;

    recency_slot_list_with_expiry #(
        .RING_SLOTS (RING_SLOTS),
        .TAG_BITS   (TAG_BITS)
    ) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_time_to_live (cfg_time_to_live),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_entry_tag      (s_entry_tag),
        .s_now_time       (s_now_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_slot_index     (m_slot_index),
        .m_slot_tag       (m_slot_tag),
        .m_evicted        (m_evicted),
        .m_present        (m_present),
        .m_last_result    (m_last_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ring predictor.
    // ------------------------------------------------------------------

    // Puts the shadow state into its post-reset shape: the sentinel slot 0
    // links to itself and is the only slot marked busy.
    function automatic void clear_ring();
        for (int unsigned i = 0; i < RING_SLOTS; i++) begin
            prev_link[i]  = '0;
            next_link[i]  = '0;
            slot_busy[i]  = 1'b0;
            slot_time[i]  = '0;
            slot_label[i] = '0;
        end
        slot_busy[0] = 1'b1;
        ttl_shadow   = rsl_pkg::TTL_RESET;
    endfunction

    // Appends one result to the list of results still owed.
    function automatic void enqueue_report(input slot_report_t rep);
        pending_reports = {pending_reports, rep};
    endfunction

    // Takes a slot out of the ring and frees it.
    function automatic void drop_slot(input int unsigned slot);
        int unsigned p;
        int unsigned n;
        p = 32'(prev_link[slot]);
        n = 32'(next_link[slot]);
        next_link[p]    = n[3:0];
        prev_link[n]    = p[3:0];
        slot_busy[slot] = 1'b0;
    endfunction

    // Applies one accepted transaction to the shadow ring and queues the
    // results it must produce.
    function automatic void predict_item(input logic kind, input logic [15:0] tag,
                                         input logic [rsl_pkg::TIME_W-1:0] now_ms);
        slot_report_t rep;
        slot_report_t held;
        bit           have_held;
        int unsigned  slot;
        int unsigned  head;
        int unsigned  cur;
        int unsigned  nxt;
        int unsigned  steps;
        logic [rsl_pkg::TIME_W-1:0] age;
        bit           evict;

        if (kind == rsl_pkg::KIND_ADD) begin
            // The lowest free slot wins; a full table recycles the oldest entry.
            slot  = 0;
            evict = 1'b0;
            for (int unsigned s = 1; s < RING_SLOTS; s++) begin
                if (slot == 0 && !slot_busy[s]) begin
                    slot = s;
                end
            end
            if (slot == 0) begin
                slot = 32'(prev_link[0]);
                drop_slot(slot);
                evict = 1'b1;
            end
            head = 32'(next_link[0]);
            prev_link[slot]  = '0;
            next_link[slot]  = head[3:0];
            prev_link[head]  = slot[3:0];
            next_link[0]     = slot[3:0];
            slot_busy[slot]  = 1'b1;
            slot_time[slot]  = '0;
            slot_label[slot] = tag;
            rep.slot_index  = slot[rsl_pkg::OUT_SLOT_W-1:0];
            rep.slot_tag    = tag;
            rep.evicted     = evict;
            rep.present     = 1'b1;
            rep.last_result = 1'b1;
            enqueue_report(rep);
        end else begin
            // Walk from newest to oldest. A survivor is held back by one
            // step so that the final one can carry the last-result flag.
            have_held = 1'b0;
            held      = '0;
            steps     = 0;
            cur       = 32'(next_link[0]);
            while (cur != 0 && steps < RING_SLOTS - 1) begin
                nxt = 32'(next_link[cur]);
                if (slot_time[cur] == '0) begin
                    slot_time[cur] = now_ms;
                end
                age = now_ms - slot_time[cur];
                if (age > ttl_shadow) begin
                    drop_slot(cur);
                end else begin
                    if (have_held) begin
                        enqueue_report(held);
                    end
                    held.slot_index  = cur[rsl_pkg::OUT_SLOT_W-1:0];
                    held.slot_tag    = slot_label[cur];
                    held.evicted     = 1'b0;
                    held.present     = 1'b1;
                    held.last_result = 1'b0;
                    have_held        = 1'b1;
                end
                cur = nxt;
                steps++;
            end
            if (have_held) begin
                held.last_result = 1'b1;
                enqueue_report(held);
            end else begin
                // Nothing survived: a single empty report closes the tick.
                rep             = '0;
                rep.last_result = 1'b1;
                enqueue_report(rep);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking, receiver back-pressure and the hang watchdog.
    // ------------------------------------------------------------------

    // Outputs are sampled right after the edge, so the values seen are the
    // ones the block presented when the edge arrived.
    always @(posedge aclk) begin
        slot_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result transaction: slot_index %0d slot_tag 0x%04h",
                       m_slot_index, m_slot_tag);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_slot_index !== want.slot_index) begin
                    $error("slot_index: expected %0d, actual %0d",
                           want.slot_index, m_slot_index);
                    fail_count++;
                end
                if (m_slot_tag !== want.slot_tag) begin
                    $error("slot_tag: expected 0x%04h, actual 0x%04h",
                           want.slot_tag, m_slot_tag);
                    fail_count++;
                end
                if (m_evicted !== want.evicted) begin
                    $error("evicted: expected %0b, actual %0b", want.evicted, m_evicted);
                    fail_count++;
                end
                if (m_present !== want.present) begin
                    $error("present: expected %0b, actual %0b", want.present, m_present);
                    fail_count++;
                end
                if (m_last_result !== want.last_result) begin
                    $error("last_result: expected %0b, actual %0b",
                           want.last_result, m_last_result);
                    fail_count++;
                end
            end
        end
    end

    // The receiver stalls in roughly a third of the cycles unless a
    // gap-free stretch is running.
    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(99) >= 32);
    end

    // Any accepted transaction on any channel proves the block is alive.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks.
    // ------------------------------------------------------------------

    // Offers one input transaction and returns in the time step of its
    // acceptance, with s_valid still high. The next call either keeps it
    // high or lowers it during a random gap, so s_valid never gets two
    // assignments in one step.
    task automatic send_item(input logic kind, input logic [15:0] tag,
                             input logic [rsl_pkg::TIME_W-1:0] now_ms);
        if (!no_gaps) begin
            while ($urandom_range(99) < 32) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_entry_tag <= tag;
        s_now_time  <= now_ms;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_item(kind, tag, now_ms);
    endtask

    // Lowers s_valid; called in the step in which the last transaction
    // was accepted.
    task automatic stop_sending();
        s_valid <= 1'b0;
    endtask

    // Waits until every predicted result has been seen.
    task automatic wait_for_results();
        do begin
            @(posedge aclk);
        end while (pending_reports.size() != 0);
    endtask

    // Writes time_to_live. Only called with the block idle and s_valid low.
    task automatic write_ttl(input logic [rsl_pkg::TIME_W-1:0] value);
        cfg_valid        <= 1'b1;
        cfg_time_to_live <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        ttl_shadow = value;
        cfg_valid <= 1'b0;
    endtask

    // Brings the block to rest and loads a new expiry setting.
    task automatic reconfigure(input logic [rsl_pkg::TIME_W-1:0] value);
        stop_sending();
        wait_for_results();
        write_ttl(value);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // A tick on the empty ring gives a single empty report, at both ends
    // of the time range.
    task automatic test_empty_ring();
        send_item(rsl_pkg::KIND_TICK, 16'hFFFF, 32'h0000_0000);
        send_item(rsl_pkg::KIND_TICK, 16'h0000, 32'hFFFF_FFFF);
    endtask

    // Fills all nine slots, lists them at time zero (stamps stay clear),
    // forces two evictions of the oldest entries, then ages the whole
    // ring up to and just past the default time-to-live.
    task automatic test_fill_and_evict();
        logic [15:0] tags[4];
        tags = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
        for (int i = 0; i < 9; i++) begin
            send_item(rsl_pkg::KIND_ADD, (i < 4) ? tags[i] : 16'($urandom_range(65535)),
                      32'hFFFF_FFFF);
        end
        send_item(rsl_pkg::KIND_TICK, 16'h1234, 32'd0);
        send_item(rsl_pkg::KIND_ADD, 16'hFFFF, 32'd0);
        send_item(rsl_pkg::KIND_ADD, 16'h0001, 32'd0);
        send_item(rsl_pkg::KIND_TICK, 16'h0000, 32'd1000);
        // An age equal to the limit still survives; one more expires all.
        send_item(rsl_pkg::KIND_TICK, 16'h0000, 32'd1000 + rsl_pkg::TTL_RESET);
        send_item(rsl_pkg::KIND_TICK, 16'h0000, 32'd1001 + rsl_pkg::TTL_RESET);
    endtask

    // Exercises the two ends of time_to_live, including an age that wraps
    // around the 32-bit time range.
    task automatic test_ttl_extremes();
        reconfigure(32'h0000_0000);
        send_item(rsl_pkg::KIND_ADD, 16'h8001, 32'd0);
        send_item(rsl_pkg::KIND_TICK, 16'h0000, 32'd500);
        send_item(rsl_pkg::KIND_TICK, 16'h0000, 32'd500);
        send_item(rsl_pkg::KIND_TICK, 16'h0000, 32'd501);
        reconfigure(32'hFFFF_FFFF);
        send_item(rsl_pkg::KIND_ADD, 16'h7FFE, 32'd0);
        send_item(rsl_pkg::KIND_TICK, 16'h0000, 32'hFFFF_FFFF);
        send_item(rsl_pkg::KIND_TICK, 16'h0000, 32'hFFFF_FFFE);
    endtask

    // One random phase under a given expiry setting. Ticks mostly follow a
    // rising clock so entries age in a realistic way; a few jump to a
    // random time or to zero. Optionally the sender stops halfway until the
    // block has delivered every result.
    task automatic run_random_phase(input logic [rsl_pkg::TIME_W-1:0] ttl_value,
                                    input int unsigned count, input bit pause_midway,
                                    input int unsigned max_step);
        int unsigned pick;
        logic [rsl_pkg::TIME_W-1:0] tick_ms;
        reconfigure(ttl_value);
        for (int unsigned i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) begin
                stop_sending();
                wait_for_results();
            end
            if ($urandom_range(99) < 55) begin
                send_item(rsl_pkg::KIND_ADD, 16'($urandom_range(65535)), $urandom);
            end else begin
                pick = $urandom_range(99);
                if (pick < 85) begin
                    clock_ms = clock_ms + $urandom_range(max_step);
                    tick_ms  = clock_ms;
                end else if (pick < 95) begin
                    tick_ms = $urandom;
                end else begin
                    tick_ms = '0;
                end
                send_item(rsl_pkg::KIND_TICK, 16'($urandom_range(65535)), tick_ms);
            end
        end
    endtask

    initial begin
        clear_ring();
        clock_ms = $urandom;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_ring();
        test_fill_and_evict();
        test_ttl_extremes();

        // Settings from tight to never-expiring; the third phase runs
        // without any idling on either side.
        run_random_phase(32'($urandom_range(1, 60)), 57, 1'b0, 25);
        run_random_phase(rsl_pkg::TTL_RESET, 57, 1'b1, 2000);
        no_gaps = 1'b1;
        run_random_phase(32'h0000_0000, 57, 1'b0, 3);
        no_gaps = 1'b0;
        run_random_phase(32'hFFFF_FFFF, 57, 1'b0, 1000);
        run_random_phase($urandom, 57, 1'b0, 32'hFFFF_FFFF);

        stop_sending();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/rsl_pkg.sv
src/rsl_ram.sv
src/recency_slot_list_with_expiry.sv
dv/recency_slot_list_with_expiry_tb.sv
